[src/shp_pkg.sv]
`timescale 1ns / 1ps

package shp_pkg;

    // Phase and fixed-point geometry
    localparam int PH_BITS  = 32;
    localparam int Q_SHIFT  = 30;
    localparam int OUT_BITS = 25;
    localparam int FOV_BITS = 24;
    localparam int QBITS    = 25;

    // Pipeline depths of the sine and divider units
    localparam int SIN_LAT  = 8;
    localparam int DIV_LAT  = QBITS + 2;

    localparam logic [PH_BITS-1:0]  QUARTER_TURN = 32'h4000_0000;
    localparam logic [FOV_BITS-1:0] FOV_RESET    = 24'h01_0000;

    // Odd polynomial coefficients of the quarter-wave sine, Q30
    typedef logic [31:0] coef_t;
    localparam coef_t K11 = 32'd3864;
    localparam int    HORNER_N = 5;
    localparam coef_t HORNER_K [HORNER_N] = '{
        32'd172272, 32'd5026995, 32'd85569305, 32'd693598669, 32'd1686629713
    };

    typedef enum logic [1:0] {
        REG_OBS_RA  = 2'd0,
        REG_OBS_DEC = 2'd1,
        REG_FOV_X   = 2'd2,
        REG_FOV_Y   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic valid;
        logic keep;
    } ctrl_t;

    // Signed Q30 product, truncated toward zero
    function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [63:0] adj;
        p   = a * b;
        adj = p + ((p < 0) ? 64'sd1073741823 : 64'sd0);
        return adj[61:30];
    endfunction

endpackage

[src/star_horizon_projection_unit.sv]
`timescale 1ns / 1ps

// Star horizon projection unit.
// Input channel: one catalog star per request (star_ra, star_dec), taken at an
// edge with star_valid high and star_stall low. Output channel: the gnomonic
// plane position (plane_x, plane_y) of each star above the horizon and inside
// the field of view; other stars yield no request at all.
// Configuration: APB writes to observer_ra, observer_dec, tan_half_fov_x and
// tan_half_fov_y at byte addresses 0, 4, 8 and 12; write only while idle.
// Pipeline: 39 register stages from the accepting edge to plane_valid: the
// eight-stage sine polynomial, three product stages, the 27-stage restoring
// divider (its bit stages each resolve one quotient bit) and the output register.
// Throughput: one star per cycle, sustained while plane_stall stays low.
// Reset: clears all valid bits and loads the register defaults (observer at
// zero, both half-field tangents at 1.0).
// Stall: a waiting result holds in the output register; the pipeline keeps
// accepting stars while its tail has no result to deliver, and freezes in
// place otherwise, so nothing is lost or repeated.
module star_horizon_projection_unit #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   star_valid,
    output logic                   star_stall,
    input  logic [ANGLE_BITS-1:0]  star_ra,
    input  logic signed [ANGLE_BITS-1:0] star_dec,
    output logic                   plane_valid,
    input  logic                   plane_stall,
    output logic signed [shp_pkg::OUT_BITS-1:0] plane_x,
    output logic signed [shp_pkg::OUT_BITS-1:0] plane_y
);

    localparam int PB  = shp_pkg::PH_BITS;
    localparam int SL  = shp_pkg::SIN_LAT;
    localparam int FB  = shp_pkg::FOV_BITS;

    // Configuration registers
    logic [ANGLE_BITS-1:0] obs_ra_reg;
    logic [ANGLE_BITS-1:0] obs_dec_reg;
    logic [FB-1:0]         fov_x_reg;
    logic [FB-1:0]         fov_y_reg;

    shp_pkg::reg_idx_t cfg_idx;
    assign cfg_idx = shp_pkg::reg_idx_t'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obs_ra_reg  <= '0;
            obs_dec_reg <= '0;
            fov_x_reg   <= shp_pkg::FOV_RESET;
            fov_y_reg   <= shp_pkg::FOV_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (cfg_idx)
                shp_pkg::REG_OBS_RA:  obs_ra_reg  <= pwdata[ANGLE_BITS-1:0];
                shp_pkg::REG_OBS_DEC: obs_dec_reg <= pwdata[ANGLE_BITS-1:0];
                shp_pkg::REG_FOV_X:   fov_x_reg   <= pwdata[FB-1:0];
                shp_pkg::REG_FOV_Y:   fov_y_reg   <= pwdata[FB-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            shp_pkg::REG_OBS_RA:  prdata = 32'(obs_ra_reg);
            shp_pkg::REG_OBS_DEC: prdata = 32'(obs_dec_reg);
            shp_pkg::REG_FOV_X:   prdata = 32'(fov_x_reg);
            shp_pkg::REG_FOV_Y:   prdata = 32'(fov_y_reg);
            default:              prdata = '0;
        endcase
    end

    // Flow control: advance unless a deliverable result meets a stalled output
    logic adv;
    logic tail_deliver;
    shp_pkg::ctrl_t ctrl_x, ctrl_y;
    logic ok_x, ok_y;
    logic signed [shp_pkg::OUT_BITS-1:0] quo_x, quo_y;
    logic plane_valid_reg;

    assign tail_deliver = ctrl_x.valid && ctrl_x.keep && ok_x && ok_y;
    assign adv          = !plane_valid_reg || !plane_stall || !tail_deliver;
    assign star_stall   = !adv;

    // Phases of hour angle, star declination and observer declination
    logic [ANGLE_BITS-1:0] hour;
    logic [PB-1:0] ph_t, ph_d, ph_o;

    always_comb
    begin
        hour = star_ra - obs_ra_reg;
        ph_t = PB'(hour) << (PB - ANGLE_BITS);
        ph_d = PB'(star_dec) << (PB - ANGLE_BITS);
        ph_o = PB'(obs_dec_reg) << (PB - ANGLE_BITS);
    end

    logic signed [31:0] st, ct, sd, cd, so, co;

    shp_sine u_sin_t (.clk(clk), .en(adv), .ph(ph_t), .sin_q30(st));
    shp_sine u_cos_t (.clk(clk), .en(adv), .ph(ph_t + shp_pkg::QUARTER_TURN), .sin_q30(ct));
    shp_sine u_sin_d (.clk(clk), .en(adv), .ph(ph_d), .sin_q30(sd));
    shp_sine u_cos_d (.clk(clk), .en(adv), .ph(ph_d + shp_pkg::QUARTER_TURN), .sin_q30(cd));
    shp_sine u_sin_o (.clk(clk), .en(adv), .ph(ph_o), .sin_q30(so));
    shp_sine u_cos_o (.clk(clk), .en(adv), .ph(ph_o + shp_pkg::QUARTER_TURN), .sin_q30(co));

    // Valid bits beside the sine pipelines, then the product stages
    logic [SL-1:0] sv_reg;
    logic t1_valid_reg, t2_valid_reg;
    shp_pkg::ctrl_t t3_ctrl_reg;

    logic signed [31:0] t1_p1_reg, t1_p2_reg, t1_nx_reg, t1_p3_reg, t1_p4_reg, t1_ct_reg;
    logic signed [31:0] t2_p1_reg, t2_p3_reg, t2_nx_reg, t2_p5_reg, t2_p6_reg;
    logic signed [32:0] cosz_next;
    logic [31:0]        t3_den_reg;
    logic signed [32:0] t3_nx_reg, t3_ny_reg;

    assign cosz_next = 33'(t2_p1_reg) + 33'(t2_p5_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg       <= '0;
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_ctrl_reg  <= '0;
        end
        else if (adv)
        begin
            sv_reg       <= {sv_reg[SL-2:0], star_valid};
            t1_valid_reg <= sv_reg[SL-1];
            t2_valid_reg <= t1_valid_reg;
            t3_ctrl_reg  <= {t2_valid_reg, (cosz_next > 0)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_p1_reg  <= shp_pkg::mul30(sd, so);
            t1_p2_reg  <= shp_pkg::mul30(cd, co);
            t1_nx_reg  <= shp_pkg::mul30(cd, st);
            t1_p3_reg  <= shp_pkg::mul30(sd, co);
            t1_p4_reg  <= shp_pkg::mul30(cd, so);
            t1_ct_reg  <= ct;
            t2_p1_reg  <= t1_p1_reg;
            t2_p3_reg  <= t1_p3_reg;
            t2_nx_reg  <= t1_nx_reg;
            t2_p5_reg  <= shp_pkg::mul30(t1_p2_reg, t1_ct_reg);
            t2_p6_reg  <= shp_pkg::mul30(t1_p4_reg, t1_ct_reg);
            t3_den_reg <= cosz_next[31:0];
            t3_nx_reg  <= 33'(t2_nx_reg);
            t3_ny_reg  <= 33'(t2_p3_reg) - 33'(t2_p6_reg);
        end
    end

    // Divide both numerators by cos z and test them against the field
    shp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .clk(clk), .rst_n(rst_n), .en(adv), .ctrl_in(t3_ctrl_reg),
        .num(t3_nx_reg), .den(t3_den_reg), .fov(fov_x_reg),
        .ctrl_out(ctrl_x), .quo(quo_x), .ok(ok_x)
    );

    shp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .clk(clk), .rst_n(rst_n), .en(adv), .ctrl_in(t3_ctrl_reg),
        .num(t3_ny_reg), .den(t3_den_reg), .fov(fov_y_reg),
        .ctrl_out(ctrl_y), .quo(quo_y), .ok(ok_y)
    );

    // Output register: load when empty or taken, hold while stalled
    logic load_out;
    assign load_out = !plane_valid_reg || !plane_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            plane_valid_reg <= tail_deliver;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out && tail_deliver)
        begin
            plane_x <= quo_x;
            plane_y <= quo_y;
        end
    end

    assign plane_valid = plane_valid_reg;

    logic [shp_pkg::OUT_BITS-1:0] mag_x, mag_y;
    always_comb
    begin
        mag_x = plane_x[shp_pkg::OUT_BITS-1] ? -plane_x : plane_x;
        mag_y = plane_y[shp_pkg::OUT_BITS-1] ? -plane_y : plane_y;
    end

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !plane_valid |-> !star_stall)
        else $error("input stalled with empty output register");

    a_x_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        plane_valid |-> (mag_x <= shp_pkg::OUT_BITS'(fov_x_reg)))
        else $error("plane_x outside horizontal field");

    a_y_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        plane_valid |-> (mag_y <= shp_pkg::OUT_BITS'(fov_y_reg)))
        else $error("plane_y outside vertical field");

    a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_x == ctrl_y)
        else $error("divider lanes out of step");

endmodule

[src/shp_sine.sv]
`timescale 1ns / 1ps

module shp_sine (
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        ph,
    output logic signed [31:0] sin_q30
);

    logic [30:0] x_reg   [0:6];
    logic        neg_reg [0:6];
    logic [30:0] x2_reg  [1:5];
    logic [31:0] acc_reg [2:6];

    logic [30:0] x_next;
    logic [61:0] sq;
    logic [62:0] fin_prod;
    logic [32:0] fin_val;
    logic [31:0] fin_clamp;

    always_comb
    begin
        x_next = ph[30] ? (31'h4000_0000 - {1'b0, ph[29:0]}) : {1'b0, ph[29:0]};
        sq     = x_reg[0] * x_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= x_next;
            neg_reg[0] <= ph[31];
            x_reg[1]   <= x_reg[0];
            neg_reg[1] <= neg_reg[0];
            x2_reg[1]  <= sq[60:30];
        end
    end

    // Horner steps, one multiply each
    for (genvar s = 2; s <= 6; s++)
    begin : g_horner
        logic [31:0] acc_in;
        logic [62:0] prod;
        if (s == 2)
        begin : g_first
            assign acc_in = shp_pkg::K11;
        end
        else
        begin : g_rest
            assign acc_in = acc_reg[s-1];
        end
        assign prod = acc_in * x2_reg[s-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s]   <= x_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                acc_reg[s] <= shp_pkg::HORNER_K[s-2] - prod[61:30];
            end
        end

        if (s <= 5)
        begin : g_x2
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x2_reg[s] <= x2_reg[s-1];
                end
            end
        end
    end

    always_comb
    begin
        fin_prod  = acc_reg[6] * x_reg[6];
        fin_val   = fin_prod[62:30];
        fin_clamp = (fin_val > 33'h4000_0000) ? 32'h4000_0000 : fin_val[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_q30 <= neg_reg[6] ? -$signed(fin_clamp) : $signed(fin_clamp);
        end
    end

endmodule

[src/shp_div.sv]
`timescale 1ns / 1ps

module shp_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  shp_pkg::ctrl_t          ctrl_in,
    input  logic signed [32:0]      num,
    input  logic [31:0]             den,
    input  logic [shp_pkg::FOV_BITS-1:0] fov,
    output shp_pkg::ctrl_t          ctrl_out,
    output logic signed [shp_pkg::OUT_BITS-1:0] quo,
    output logic                    ok
);

    localparam int QB = shp_pkg::QBITS;
    localparam int MW = 33 + FRAC_BITS;
    localparam int RW = (MW > 32 + QB) ? MW : 32 + QB;

    logic [RW-1:0]   rem_reg  [0:QB];
    logic [QB-1:0]   q_reg    [0:QB];
    logic [31:0]     den_reg  [0:QB];
    logic            ovf_reg  [0:QB];
    logic            sgn_reg  [0:QB];
    shp_pkg::ctrl_t  ctrl_reg [0:QB];

    logic [32:0]   mag;
    logic [RW-1:0] mag_sh;

    always_comb
    begin
        mag    = num[32] ? 33'(-num) : 33'(num);
        mag_sh = RW'(mag) << FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg[0] <= '0;
        end
        else if (en)
        begin
            ctrl_reg[0] <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= mag_sh;
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            sgn_reg[0] <= num[32];
            ovf_reg[0] <= mag_sh >= (RW'(den) << QB);
        end
    end

    // One quotient bit per stage, high bit first
    for (genvar k = 1; k <= QB; k++)
    begin : g_bit
        localparam int B = QB - k;
        logic [RW-1:0] trial;
        logic          take;
        assign trial = RW'(den_reg[k-1]) << B;
        assign take  = rem_reg[k-1] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctrl_reg[k] <= '0;
            end
            else if (en)
            begin
                ctrl_reg[k] <= ctrl_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]    <= take ? rem_reg[k-1] - trial : rem_reg[k-1];
                q_reg[k]      <= q_reg[k-1] | (QB'(take) << B);
                den_reg[k]    <= den_reg[k-1];
                sgn_reg[k]    <= sgn_reg[k-1];
                ovf_reg[k]    <= ovf_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_out <= '0;
        end
        else if (en)
        begin
            ctrl_out <= ctrl_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok  <= !ovf_reg[QB] && (q_reg[QB] <= QB'(fov));
            quo <= sgn_reg[QB] ? -$signed(q_reg[QB]) : $signed(q_reg[QB]);
        end
    end

endmodule
